/* hw/rtl/tts_pkg.sv */
// Shared types and constants of the timer table scheduler.
// No dependencies; imported by tts_cell, tts_ctrl and timer_table_scheduler.
`default_nettype none

package tts_pkg;

  localparam int NUM_TIMERS = 4;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MAX_FIRES  = 60;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

  localparam int S_TDATA_W  = 72;  // delay 32, elapsed 4, cancel id 32, pad
  localparam int M_TDATA_W  = 40;  // timer id 32, success 1, pad

  localparam logic [1:0] MODE_ONESHOT = 2'd0;
  localparam logic [1:0] MODE_REPEAT  = 2'd1;
  localparam logic [1:0] MODE_CANCEL  = 2'd2;
  localparam logic [1:0] MODE_ADVANCE = 2'd3;

  localparam logic [1:0] KIND_SCHEDULED = 2'd0;
  localparam logic [1:0] KIND_REFUSED   = 2'd1;
  localparam logic [1:0] KIND_CANCEL    = 2'd2;
  localparam logic [1:0] KIND_FIRED     = 2'd3;

  typedef enum logic [1:0] {
    OP_SCHED  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_FIRE   = 2'd2
  } op_e;

  // token walking the cell chain, one cell per cycle
  typedef struct packed {
    logic             active;
    op_e              op;
    logic             rep;
    logic [31:0]      arg;      // delay / interval or cancel id
    logic             found;
    logic [31:0]      best_id;
    logic [IDX_W-1:0] idx;
  } token_t;

  // firing update broadcast to the chain
  typedef struct packed {
    logic             fire;
    logic [IDX_W-1:0] idx;
  } commit_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] id;
    logic        ok;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/tts_cell.sv */
// One timer slot of the chain: holds the slot and handles the passing token.
// Depends on tts_pkg.
`default_nettype none

module tts_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire [tts_pkg::IDX_W-1:0] cell_idx_i,
  input  wire [63:0]               now_i,
  input  wire [31:0]               next_id_i,
  input  wire tts_pkg::token_t     tok_i,
  output tts_pkg::token_t          tok_o,
  input  wire tts_pkg::commit_t    commit_i
);
  import tts_pkg::*;

  logic        valid_q, valid_d;
  logic [31:0] id_q, id_d;
  logic [63:0] due_q, due_d;
  logic [31:0] ival_q, ival_d;
  logic        rep_q, rep_d;
  token_t      tok_q, tok_d;
  logic        due_ok;

  assign due_ok = valid_q && (due_q <= now_i);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    due_d   = due_q;
    ival_d  = ival_q;
    rep_d   = rep_q;
    tok_d   = tok_i;
    if (tok_i.active) begin
      case (tok_i.op)
        OP_SCHED: begin
          if (!tok_i.found && !valid_q) begin
            tok_d.found = 1'b1;
            tok_d.idx   = cell_idx_i;
            valid_d     = 1'b1;
            id_d        = next_id_i;
            due_d       = now_i + {32'd0, tok_i.arg};
            ival_d      = tok_i.rep ? tok_i.arg : 32'd0;
            rep_d       = tok_i.rep;
          end
        end
        OP_CANCEL: begin
          if (!tok_i.found && valid_q && (tok_i.arg != 32'd0) && (id_q == tok_i.arg)) begin
            tok_d.found = 1'b1;
            tok_d.idx   = cell_idx_i;
            valid_d     = 1'b0;
          end
        end
        OP_FIRE: begin
          if (due_ok && (!tok_i.found || (id_q < tok_i.best_id))) begin
            tok_d.found   = 1'b1;
            tok_d.best_id = id_q;
            tok_d.idx     = cell_idx_i;
          end
        end
        default: ;
      endcase
    end
    if (commit_i.fire && (commit_i.idx == cell_idx_i)) begin
      if (rep_q) begin
        due_d = due_q + {32'd0, ival_q};
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    due_q  <= due_d;
    ival_q <= ival_d;
    rep_q  <= rep_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

/* hw/rtl/tts_ctrl.sv */
// Sequencer of the timer table scheduler: decodes transactions, launches
// tokens into the cell chain, applies firings and drives the result register.
// Depends on tts_pkg.
`default_nettype none

module tts_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire [1:0]                    s_axis_tuser_i,
  input  wire [tts_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  output logic [1:0]                   m_axis_tuser_o,
  output logic                         m_axis_tlast_o,
  output logic [tts_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output tts_pkg::token_t              tok_o,
  input  wire tts_pkg::token_t         tok_exit_i,
  output tts_pkg::commit_t             commit_o,
  output logic [63:0]                  now_o,
  output logic [31:0]                  next_id_o
);
  import tts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e                state_q, state_d;
  token_t                tok_q, tok_d;
  logic [63:0]           now_q, now_d;
  logic [31:0]           next_id_q, next_id_d;
  logic                  pend_q, pend_d;
  logic [31:0]           pend_id_q, pend_id_d;
  logic [FIRE_CNT_W-1:0] cnt_q, cnt_d;
  logic                  resweep_q, resweep_d;
  result_t               res_q, res_d;
  result_t               out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;
  logic [31:0]           in_delay;
  logic [3:0]            in_elapsed;
  logic [31:0]           in_cid;

  assign in_delay   = s_axis_tdata_i[31:0];
  assign in_elapsed = s_axis_tdata_i[35:32];
  assign in_cid     = s_axis_tdata_i[67:36];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d     = state_q;
    tok_d       = tok_q;
    tok_d.active = 1'b0;
    now_d       = now_q;
    next_id_d   = next_id_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    cnt_d       = cnt_q;
    resweep_d   = resweep_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    commit_o    = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          tok_d.found   = 1'b0;
          tok_d.best_id = '0;
          tok_d.idx     = '0;
          tok_d.rep     = (s_axis_tuser_i == MODE_REPEAT);
          tok_d.arg     = in_delay;
          case (s_axis_tuser_i)
            MODE_ONESHOT, MODE_REPEAT: begin
              if ((s_axis_tuser_i == MODE_REPEAT) && (in_delay == 32'd0)) begin
                res_d     = '{kind: KIND_REFUSED, id: 32'd0, ok: 1'b0, last: 1'b1};
                resweep_d = 1'b0;
                state_d   = ST_EMIT;
              end else begin
                tok_d.active = 1'b1;
                tok_d.op     = OP_SCHED;
                state_d      = ST_SWEEP;
              end
            end
            MODE_CANCEL: begin
              tok_d.active = 1'b1;
              tok_d.op     = OP_CANCEL;
              tok_d.arg    = in_cid;
              state_d      = ST_SWEEP;
            end
            default: begin
              now_d        = now_q + {60'd0, in_elapsed};
              cnt_d        = '0;
              pend_d       = 1'b0;
              tok_d.active = 1'b1;
              tok_d.op     = OP_FIRE;
              state_d      = ST_SWEEP;
            end
          endcase
        end
      end

      ST_SWEEP: begin
        if (tok_exit_i.active) begin
          resweep_d = 1'b0;
          case (tok_exit_i.op)
            OP_SCHED: begin
              state_d = ST_EMIT;
              if (tok_exit_i.found) begin
                res_d     = '{kind: KIND_SCHEDULED, id: next_id_q, ok: 1'b1, last: 1'b1};
                next_id_d = (next_id_q == '1) ? 32'd1 : next_id_q + 32'd1;
              end else begin
                res_d = '{kind: KIND_REFUSED, id: 32'd0, ok: 1'b0, last: 1'b1};
              end
            end
            OP_CANCEL: begin
              state_d = ST_EMIT;
              res_d   = '{kind: KIND_CANCEL, id: tok_exit_i.arg, ok: tok_exit_i.found,
                          last: 1'b1};
            end
            default: begin
              tok_d.found   = 1'b0;
              tok_d.best_id = '0;
              tok_d.idx     = '0;
              tok_d.op      = OP_FIRE;
              if (tok_exit_i.found) begin
                commit_o.fire = 1'b1;
                commit_o.idx  = tok_exit_i.idx;
                cnt_d         = cnt_q + 1'b1;
                if (cnt_q == FIRE_CNT_W'(MAX_FIRES - 1)) begin
                  // limit reached: flush the held firing, then this one
                  if (pend_q) begin
                    res_d     = '{kind: KIND_FIRED, id: pend_id_q, ok: 1'b1, last: 1'b0};
                    pend_id_d = tok_exit_i.best_id;
                  end else begin
                    res_d = '{kind: KIND_FIRED, id: tok_exit_i.best_id, ok: 1'b1,
                              last: 1'b1};
                  end
                  state_d = ST_EMIT;
                end else if (pend_q) begin
                  res_d     = '{kind: KIND_FIRED, id: pend_id_q, ok: 1'b1, last: 1'b0};
                  pend_id_d = tok_exit_i.best_id;
                  resweep_d = 1'b1;
                  state_d   = ST_EMIT;
                end else begin
                  pend_d       = 1'b1;
                  pend_id_d    = tok_exit_i.best_id;
                  tok_d.active = 1'b1;
                end
              end else if (pend_q) begin
                res_d   = '{kind: KIND_FIRED, id: pend_id_q, ok: 1'b1, last: 1'b1};
                pend_d  = 1'b0;
                state_d = ST_EMIT;
              end else begin
                state_d = ST_IDLE;
              end
            end
          endcase
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          if (resweep_q) begin
            tok_d.active = 1'b1;
            state_d      = ST_SWEEP;
          end else if (pend_q) begin
            res_d  = '{kind: KIND_FIRED, id: pend_id_q, ok: 1'b1, last: 1'b1};
            pend_d = 1'b0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tok_q       <= '0;
      now_q       <= 64'd0;
      next_id_q   <= 32'd1;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      resweep_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tok_q       <= tok_d;
      now_q       <= now_d;
      next_id_q   <= next_id_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      resweep_q   <= resweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign tok_o           = tok_q;
  assign now_o           = now_q;
  assign next_id_o       = next_id_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {7'd0, out_q.ok, out_q.id};

`ifndef NO_ASSERTIONS
  a_exit_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_exit_i.active |-> state_q == ST_SWEEP)
    else $error("token left the chain outside a sweep");
  a_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIRE_CNT_W'(MAX_FIRES))
    else $error("firing count beyond limit");
  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != 32'd0)
    else $error("next id is zero");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("ready held after a transaction");
`endif

endmodule

`default_nettype wire

/* hw/rtl/timer_table_scheduler.sv */
// Top level of the timer table scheduler: sequencer plus a chain of slot cells.
// Depends on tts_pkg, tts_cell and tts_ctrl.
//
// Holds NUM_TIMERS timers, one per cell of a chain. Each transaction on the
// slave side (tuser = mode) launches a token that walks the chain one cell per
// cycle, but a repeat with zero interval is refused without a pass; the
// sequencer acts on the token when it leaves the last cell. A schedule or
// cancel makes one pass and yields one result; the next transaction is
// accepted once that result is in the output register. An advance makes one
// pass per firing, plus a final pass that finds nothing due if it stays below
// the limit, and yields up to 60 firings, the last marked by tlast. Results leave
// through a single output register; a result waiting there for m_axis_tready_i
// holds the sequencer when the next result is ready, adding the stall length.
`default_nettype none

module timer_table_scheduler (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  wire [1:0]                     s_axis_tuser_i,  // mode
  input  wire [tts_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,  // delay, elapsed, cancel id
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  output logic [1:0]                    m_axis_tuser_o,  // event_kind
  output logic                          m_axis_tlast_o,  // last
  output logic [tts_pkg::M_TDATA_W-1:0] m_axis_tdata_o   // timer_id, success
);
  import tts_pkg::*;

  token_t      tok_chain [NUM_TIMERS+1];
  commit_t     commit;
  logic [63:0] now;
  logic [31:0] next_id;

  tts_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .tok_o           (tok_chain[0]),
    .tok_exit_i      (tok_chain[NUM_TIMERS]),
    .commit_o        (commit),
    .now_o           (now),
    .next_id_o       (next_id)
  );

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    tts_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .now_i      (now),
      .next_id_i  (next_id),
      .tok_i      (tok_chain[i]),
      .tok_o      (tok_chain[i+1]),
      .commit_i   (commit)
    );
  end

endmodule

`default_nettype wire
